### design/hsfr_pkg.sv
// Shared constants, types and state codes of the header sum frame receiver.
package hsfr_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 6;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int RAM_AW      = IDX_W + 1;
    localparam int RAM_DEPTH   = 2 ** RAM_AW;
    localparam int OUT_TDATA_W = ((BYTE_W + POS_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hDD;
    localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(FRAME_BYTES - 1);

    typedef enum logic {
        ST_HUNT,
        ST_FILL
    } t_fe_state;

    // Status of the frame queue as seen by the receive and replay sides.
    typedef struct packed {
        logic full;
        logic avail;
    } t_q_status;

    typedef struct packed {
        logic              last;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
    } t_out_item;

endpackage

### design/hsfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module hsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/hsfr_front.sv
// Receive side: header hunt, frame fill into the current bank and checksum check.
module hsfr_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [hsfr_pkg::BYTE_W-1:0]         i_data,
    input  logic [hsfr_pkg::BYTE_W-1:0]         i_header,
    input  hsfr_pkg::t_q_status                 i_q_status,
    output logic                                o_push,
    output logic                                o_wr_en,
    output logic [hsfr_pkg::RAM_AW-1:0]         o_wr_addr,
    output logic [hsfr_pkg::BYTE_W-1:0]         o_wr_data
);

    hsfr_pkg::t_fe_state             r_state, n_state;
    logic [hsfr_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [hsfr_pkg::BYTE_W-1:0]     r_sum, n_sum;
    logic                            r_bank, n_bank;
    logic                            accept;
    logic                            is_header;
    logic                            is_check;
    logic                            sum_ok;

    // The current bank is free unless two finished frames are waiting for replay.
    assign o_ready   = !i_q_status.full;
    assign accept    = i_valid && o_ready;
    assign is_header = (i_data == i_header);
    assign is_check  = (r_idx == hsfr_pkg::LAST_IDX);
    assign sum_ok    = (i_data == r_sum);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hsfr_pkg::ST_HUNT: begin
                if (accept && is_header) begin
                    n_state = hsfr_pkg::ST_FILL;
                end
            end
            hsfr_pkg::ST_FILL: begin
                if (accept && is_check) begin
                    n_state = hsfr_pkg::ST_HUNT;
                end
            end
            default: n_state = hsfr_pkg::ST_HUNT;
        endcase
    end

    always_comb begin
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_bank    = r_bank;
        o_push    = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = {r_bank, r_idx};
        o_wr_data = i_data;
        unique case (r_state)
            hsfr_pkg::ST_HUNT: begin
                o_wr_addr = {r_bank, {hsfr_pkg::IDX_W{1'b0}}};
                if (accept && is_header) begin
                    o_wr_en = 1'b1;
                    n_sum   = i_data;
                    n_idx   = hsfr_pkg::IDX_W'(1);
                end
            end
            hsfr_pkg::ST_FILL: begin
                if (accept) begin
                    o_wr_en = 1'b1;
                    if (is_check) begin
                        n_idx  = '0;
                        n_sum  = '0;
                        o_push = sum_ok;
                        // A good frame is handed over; a bad one is overwritten in place.
                        n_bank = r_bank ^ sum_ok;
                    end else begin
                        n_idx = r_idx + hsfr_pkg::IDX_W'(1);
                        n_sum = r_sum + i_data;
                    end
                end
            end
            default: begin
                n_idx = '0;
                n_sum = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsfr_pkg::ST_HUNT;
            r_idx   <= '0;
            r_sum   <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
            r_bank  <= n_bank;
        end
    end

endmodule

### design/hsfr_queue.sv
// Count of checked frames that sit in the buffer banks waiting for replay.
module hsfr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_pop,
    output hsfr_pkg::t_q_status o_status
);

    logic [1:0] r_count, n_count;

    assign n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.avail = (r_count != 2'd0);

endmodule

### design/hsfr_back.sv
// Replay side: reads a checked frame out of its bank into a two-entry output queue.
module hsfr_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hsfr_pkg::t_q_status             i_q_status,
    output logic                            o_pop,
    output logic                            o_rd_en,
    output logic [hsfr_pkg::RAM_AW-1:0]     o_rd_addr,
    input  logic [hsfr_pkg::BYTE_W-1:0]     i_rd_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output hsfr_pkg::t_out_item             o_item
);

    logic                         r_rd_bank, n_rd_bank;
    logic [hsfr_pkg::IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic                         r_pend;
    logic [hsfr_pkg::IDX_W-1:0]   r_pend_idx;
    hsfr_pkg::t_out_item          r_fifo [2];
    logic                         r_wp, r_rp;
    logic [1:0]                   r_occ;
    logic [1:0]                   occ_after;
    logic [1:0]                   load;
    logic                         out_pop;
    logic                         issue;
    hsfr_pkg::t_out_item          in_item;

    assign o_valid   = (r_occ != 2'd0);
    assign o_item    = r_fifo[r_rp];
    assign out_pop   = o_valid && i_ready;

    // A read is issued only when its data is sure to find a free queue slot.
    assign occ_after = r_occ - {1'b0, out_pop};
    assign load      = occ_after + {1'b0, r_pend};
    assign issue     = i_q_status.avail && (load < 2'd2);

    assign o_rd_en   = issue;
    assign o_rd_addr = {r_rd_bank, r_rd_idx};
    assign o_pop     = issue && (r_rd_idx == hsfr_pkg::LAST_IDX);

    always_comb begin
        n_rd_idx  = r_rd_idx;
        n_rd_bank = r_rd_bank;
        if (issue) begin
            if (r_rd_idx == hsfr_pkg::LAST_IDX) begin
                n_rd_idx  = '0;
                n_rd_bank = !r_rd_bank;
            end else begin
                n_rd_idx = r_rd_idx + hsfr_pkg::IDX_W'(1);
            end
        end
    end

    assign in_item.data = i_rd_data;
    assign in_item.pos  = hsfr_pkg::POS_W'(r_pend_idx);
    assign in_item.last = (r_pend_idx == hsfr_pkg::LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_bank <= 1'b0;
            r_rd_idx  <= '0;
            r_pend    <= 1'b0;
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_occ     <= '0;
        end else begin
            r_rd_bank <= n_rd_bank;
            r_rd_idx  <= n_rd_idx;
            r_pend    <= issue;
            r_occ     <= occ_after + {1'b0, r_pend};
            if (r_pend) begin
                r_wp <= !r_wp;
            end
            if (out_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_idx <= r_rd_idx;
        end
        if (r_pend) begin
            r_fifo[r_wp] <= in_item;
        end
    end

endmodule

### design/header_sum_frame_receiver.sv
// Top level of the header sum frame receiver.
// Bytes are taken one per cycle. While hunting, bytes are dropped until one equals the
// header register (reset 0xDD); that byte and the next FRAME_BYTES-1 bytes form a frame
// whose last byte must equal the mod-256 sum of the earlier ones. A good frame is replayed
// one byte per cycle while the sink is ready, header first, with its position and tlast on
// the checksum byte; a bad frame is dropped. The frame buffer has two banks, so reception
// goes on while the previous frame is replayed; the input stalls only while two checked
// frames wait for replay. The first byte of a frame is offered once the frame has passed
// the frame count register, the registered RAM read and the output queue.
module header_sum_frame_receiver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // rx_byte[7:0]
    input  logic [7:0]                          i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // frame_byte[7:0], byte_position[13:8], zero pad above
    output logic [hsfr_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // last_of_frame
    output logic                                o_m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    // header_value[7:0]
    input  logic [7:0]                          i_cfg_data
);

    logic [hsfr_pkg::BYTE_W-1:0]  r_header;
    hsfr_pkg::t_q_status          q_status;
    logic                         push;
    logic                         pop;
    logic                         wr_en;
    logic [hsfr_pkg::RAM_AW-1:0]  wr_addr;
    logic [hsfr_pkg::BYTE_W-1:0]  wr_data;
    logic                         rd_en;
    logic [hsfr_pkg::RAM_AW-1:0]  rd_addr;
    logic [hsfr_pkg::BYTE_W-1:0]  rd_data;
    hsfr_pkg::t_out_item          out_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= hsfr_pkg::HEADER_RESET;
        end else if (i_cfg_valid) begin
            r_header <= i_cfg_data;
        end
    end

    hsfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_data     (i_s_axis_tdata),
        .i_header   (r_header),
        .i_q_status (q_status),
        .o_push     (push),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    hsfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_status (q_status)
    );

    hsfr_ram #(
        .WIDTH (hsfr_pkg::BYTE_W),
        .DEPTH (hsfr_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    hsfr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_item     (out_item)
    );

    assign o_m_axis_tdata = hsfr_pkg::OUT_TDATA_W'({out_item.pos, out_item.data});
    assign o_m_axis_tlast = out_item.last;

endmodule

### design/hsfr_checker.sv
// Port-level checker of the header sum frame receiver and its bind.
module hsfr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [hsfr_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input logic                                o_m_axis_tlast
);

    logic [hsfr_pkg::POS_W-1:0] r_exp_pos;
    logic [hsfr_pkg::POS_W-1:0] out_pos;
    logic                       out_fire;

    assign out_pos  = o_m_axis_tdata[hsfr_pkg::BYTE_W +: hsfr_pkg::POS_W];
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;

    // Expected position of the next replayed byte; frames come out whole and in order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_pos <= '0;
        end else if (out_fire) begin
            r_exp_pos <= o_m_axis_tlast ? '0 : r_exp_pos + hsfr_pkg::POS_W'(1);
        end
    end

    a_pos_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> out_pos == r_exp_pos)
        else $error("replayed byte out of order");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tlast == (out_pos == hsfr_pkg::POS_W'(hsfr_pkg::FRAME_BYTES - 1)))
        else $error("tlast does not match the end of the frame");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind header_sum_frame_receiver hsfr_checker u_hsfr_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the header sum frame receiver: byte stream in, checked frames out.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [hsfr_pkg::BYTE_W-1:0] rx;
        logic [6:0]                  n_out;
    } t_dir_row;

    localparam int DIR_N    = 34;
    localparam int N_PHASES = 8;
    localparam int PHASE_TARGET = 36;

    // Noise around the reset header, a good frame with the header value and both byte
    // extremes in its payload, then a frame whose checksum is off by one.
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{8'h00, 7'd0}, '{8'hFF, 7'd0},
        '{8'hDD, 7'd0}, '{8'h00, 7'd0}, '{8'hFF, 7'd0}, '{8'hDD, 7'd0},
        '{8'h01, 7'd0}, '{8'h80, 7'd0}, '{8'h7F, 7'd0}, '{8'hAA, 7'd0},
        '{8'h55, 7'd0}, '{8'hFE, 7'd0}, '{8'h02, 7'd0}, '{8'h10, 7'd0},
        '{8'h20, 7'd0}, '{8'h40, 7'd0}, '{8'h04, 7'd0}, '{8'h2C, 7'd16},
        '{8'hDD, 7'd0}, '{8'h11, 7'd0}, '{8'h11, 7'd0}, '{8'h11, 7'd0},
        '{8'h11, 7'd0}, '{8'h11, 7'd0}, '{8'h11, 7'd0}, '{8'h11, 7'd0},
        '{8'h11, 7'd0}, '{8'h11, 7'd0}, '{8'h11, 7'd0}, '{8'h11, 7'd0},
        '{8'h11, 7'd0}, '{8'h11, 7'd0}, '{8'h11, 7'd0}, '{8'hCC, 7'd0}
    };

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 s_valid = 1'b0;
    logic [hsfr_pkg::BYTE_W-1:0]          s_data = '0;
    logic                                 m_ready = 1'b0;
    logic                                 cfg_valid = 1'b0;
    logic [hsfr_pkg::BYTE_W-1:0]          cfg_data = '0;
    logic                                 s_ready;
    logic                                 m_valid;
    logic [hsfr_pkg::OUT_TDATA_W-1:0]     m_data;
    logic                                 m_last;
    logic                                 cfg_ready;

    // Shadow of the receiver state.
    logic [hsfr_pkg::BYTE_W-1:0] hdr_value = hsfr_pkg::HEADER_RESET;
    hsfr_pkg::t_fe_state         rx_mode = hsfr_pkg::ST_HUNT;
    logic [6:0]                  fill_count = '0;
    logic [hsfr_pkg::BYTE_W-1:0] byte_sum = '0;
    logic [hsfr_pkg::BYTE_W-1:0] frame_store [hsfr_pkg::FRAME_BYTES];
    int                          rx_result_count = 0;

    hsfr_pkg::t_out_item         frame_replay_q [$];
    logic [hsfr_pkg::BYTE_W-1:0] rx_plan [$];
    int                          mismatch_count = 0;
    int                          send_gap_pct = 0;
    int                          stall_pct = 0;

    header_sum_frame_receiver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic track_rx_byte(input logic [hsfr_pkg::BYTE_W-1:0] b);
        int k;
        rx_result_count = 0;
        if (rx_mode == hsfr_pkg::ST_HUNT) begin
            if (b == hdr_value) begin
                frame_store[0] = b;
                byte_sum = b;
                fill_count = 7'd1;
                rx_mode = hsfr_pkg::ST_FILL;
            end
        end else if (fill_count < 7'(hsfr_pkg::FRAME_BYTES - 1)) begin
            frame_store[fill_count[hsfr_pkg::IDX_W-1:0]] = b;
            byte_sum = byte_sum + b;
            fill_count = fill_count + 7'd1;
        end else begin
            // Checksum byte: the frame is replayed only when it matches the running sum.
            frame_store[hsfr_pkg::LAST_IDX] = b;
            if (b == byte_sum) begin
                for (k = 0; k < hsfr_pkg::FRAME_BYTES; k++) begin
                    frame_replay_q.push_back(hsfr_pkg::t_out_item'{
                        last: (k == hsfr_pkg::FRAME_BYTES - 1),
                        pos: hsfr_pkg::POS_W'(k),
                        data: frame_store[k[hsfr_pkg::IDX_W-1:0]]});
                end
                rx_result_count = hsfr_pkg::FRAME_BYTES;
            end
            rx_mode = hsfr_pkg::ST_HUNT;
            fill_count = '0;
            byte_sum = '0;
        end
    endtask

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_replay_byte();
        hsfr_pkg::t_out_item want;
        if (frame_replay_q.size() == 0) begin
            $display("%0t: output byte with none expected, expected none, actual tdata %0h",
                     $time, m_data);
            mismatch_count++;
        end else begin
            want = frame_replay_q.pop_front();
            compare_field("frame_byte", int'(want.data),
                          int'(m_data[hsfr_pkg::BYTE_W-1:0]));
            compare_field("byte_position", int'(want.pos),
                          int'(m_data[hsfr_pkg::BYTE_W+hsfr_pkg::POS_W-1:hsfr_pkg::BYTE_W]));
            compare_field("tdata pad", 0,
                          int'(m_data >> (hsfr_pkg::BYTE_W + hsfr_pkg::POS_W)));
            compare_field("last_of_frame", int'(want.last), int'(m_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                check_replay_byte();
            end
            if (s_valid && s_ready) begin
                track_rx_byte(s_data);
            end
            if (cfg_valid && cfg_ready) begin
                hdr_value = cfg_data;
            end
        end
    end

    // Called and returning at a falling edge.
    task automatic send_rx(input logic [hsfr_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
    endtask

    task automatic write_header(input logic [hsfr_pkg::BYTE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_outputs();
        while (frame_replay_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_SEND: begin
                send_gap_pct = 64;
                stall_pct = 0;
            end
            IDLE_RECV: begin
                send_gap_pct = 0;
                stall_pct = 64;
            end
            IDLE_BOTH: begin
                send_gap_pct = 10;
                stall_pct = 10;
            end
            default: begin
                send_gap_pct = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    // Mostly whole frames with random content; some noise, cut frames and bad checksums.
    task automatic plan_random_bytes(input int target, input bit end_mid_frame);
        logic [hsfr_pkg::BYTE_W-1:0] b;
        logic [hsfr_pkg::BYTE_W-1:0] csum;
        int len;
        rx_plan.delete();
        while (rx_plan.size() < target) begin
            repeat ($urandom_range(3)) begin
                b = 8'($urandom_range(255));
                if (b == hdr_value) b ^= 8'h01;
                rx_plan.push_back(b);
            end
            rx_plan.push_back(hdr_value);
            csum = hdr_value;
            len = ($urandom_range(9) == 0) ? $urandom_range(13) : hsfr_pkg::FRAME_BYTES - 2;
            repeat (len) begin
                b = ($urandom_range(7) == 0) ? hdr_value : 8'($urandom_range(255));
                rx_plan.push_back(b);
                csum = csum + b;
            end
            if (len == hsfr_pkg::FRAME_BYTES - 2) begin
                if ($urandom_range(4) == 0) csum ^= 8'h01 << $urandom_range(7);
                rx_plan.push_back(csum);
            end
        end
        // Leave a frame open so that the next header write lands in the middle of it.
        if (end_mid_frame) begin
            rx_plan.push_back(hdr_value);
            repeat ($urandom_range(13, 1)) rx_plan.push_back(8'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [hsfr_pkg::BYTE_W-1:0] next_hdr;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_idle(IDLE_NONE);
        for (int i = 0; i < DIR_N; i++) begin
            send_rx(DIR_ROWS[i].rx);
            if (rx_result_count != int'(DIR_ROWS[i].n_out)) begin
                $display("%0t: frame result count, expected %0d, actual %0d",
                         $time, DIR_ROWS[i].n_out, rx_result_count);
                mismatch_count++;
            end
        end
        s_valid <= 1'b0;

        for (int p = 0; p < N_PHASES; p++) begin
            drain_outputs();
            case (p)
                0: next_hdr = 8'h00;
                1: next_hdr = 8'hFF;
                3: next_hdr = hsfr_pkg::HEADER_RESET;
                default: next_hdr = 8'($urandom_range(255));
            endcase
            write_header(next_hdr);
            set_idle(t_idle_mode'(p % 4));
            plan_random_bytes(PHASE_TARGET, p[0]);
            foreach (rx_plan[i]) send_rx(rx_plan[i]);
            s_valid <= 1'b0;
        end

        while (frame_replay_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
